### design/bbas_pkg.sv
package bbas_pkg;

    localparam int TOTAL_BLOCKS    = 256;
    localparam int BLOCK_BYTES     = 64;
    localparam int RESERVED_BLOCKS = 1;

    localparam int BLK_W      = $clog2(TOTAL_BLOCKS);
    localparam int OFF_W      = $clog2(BLOCK_BYTES);
    localparam int DATA_BYTES = (TOTAL_BLOCKS - RESERVED_BLOCKS) * BLOCK_BYTES;
    localparam int ADDR_W     = $clog2(DATA_BYTES);

    localparam int SCAN_W     = 32;
    localparam int NUM_WORDS  = TOTAL_BLOCKS / SCAN_W;
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W  = $clog2(SCAN_W);

    typedef enum logic [1:0] {
        OP_ALLOCATE = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_READ     = 2'd2,
        OP_WRITE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PARAM      = 2'd1,
        ST_FULL       = 2'd2,
        ST_NOT_IN_USE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_ALLOC,
        CMD_RELEASE,
        CMD_READ,
        CMD_WRITE,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] block_number;
        logic [5:0] byte_offset;
        logic [7:0] write_byte;
        logic       transfer_end;
    } req_t;

    typedef struct packed {
        logic [7:0] result_block;
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       transfer_last;
    } rsp_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BLK_W-1:0]  blk;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wbyte;
        logic              last;
    } cmd_t;

    function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [SCAN_W-1:0] word);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

### design/bbas_front.sv
module bbas_front (
    input  logic            req_valid,
    output logic            req_stall,
    input  bbas_pkg::req_t  req,
    input  logic            store_ready,
    output logic            cmd_valid,
    input  logic            cmd_stall,
    output bbas_pkg::cmd_t  cmd
);

    logic [bbas_pkg::BLK_W:0]  blk_ext;
    logic [bbas_pkg::OFF_W:0]  off_ext;
    logic                      blk_ok;
    logic                      off_ok;
    logic [bbas_pkg::ADDR_W:0] idx_wide;

    assign req_stall = cmd_stall || !store_ready;
    assign cmd_valid = req_valid && store_ready;

    assign blk_ext = {1'b0, req.block_number};
    assign off_ext = {1'b0, req.byte_offset};
    assign blk_ok  = (blk_ext >= (bbas_pkg::BLK_W + 1)'(bbas_pkg::RESERVED_BLOCKS))
                  && (blk_ext <  (bbas_pkg::BLK_W + 1)'(bbas_pkg::TOTAL_BLOCKS));
    assign off_ok  = off_ext < (bbas_pkg::OFF_W + 1)'(bbas_pkg::BLOCK_BYTES);

    // data store skips the reserved blocks
    assign idx_wide = (bbas_pkg::ADDR_W + 1)'(req.block_number
                      - bbas_pkg::BLK_W'(bbas_pkg::RESERVED_BLOCKS))
                    * (bbas_pkg::ADDR_W + 1)'(bbas_pkg::BLOCK_BYTES)
                    + (bbas_pkg::ADDR_W + 1)'(req.byte_offset);

    always_comb
    begin
        cmd.blk   = req.block_number;
        cmd.addr  = idx_wide[bbas_pkg::ADDR_W-1:0];
        cmd.wbyte = req.write_byte;
        cmd.last  = 1'b0;
        cmd.kind  = bbas_pkg::CMD_ERROR;
        unique case (req.operation)
            bbas_pkg::OP_ALLOCATE:
            begin
                cmd.kind = bbas_pkg::CMD_ALLOC;
            end
            bbas_pkg::OP_RELEASE:
            begin
                cmd.kind = blk_ok ? bbas_pkg::CMD_RELEASE : bbas_pkg::CMD_ERROR;
            end
            bbas_pkg::OP_READ:
            begin
                cmd.last = req.transfer_end;
                cmd.kind = (blk_ok && off_ok) ? bbas_pkg::CMD_READ : bbas_pkg::CMD_ERROR;
            end
            bbas_pkg::OP_WRITE:
            begin
                cmd.last = req.transfer_end;
                cmd.kind = (blk_ok && off_ok) ? bbas_pkg::CMD_WRITE : bbas_pkg::CMD_ERROR;
            end
            default:
            begin
                cmd.kind = bbas_pkg::CMD_ERROR;
            end
        endcase
    end

endmodule

### design/bbas_queue.sv
module bbas_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_stall,
    input  bbas_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_take,
    output bbas_pkg::cmd_t  pop_cmd
);

    bbas_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign push_stall = count_reg == 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign push = push_valid && !push_stall;
    assign pop  = pop_take && pop_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/bbas_back.sv
module bbas_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_take,
    input  bbas_pkg::cmd_t  cmd,
    output logic            store_ready,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bbas_pkg::rsp_t  rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } state_t;

    state_t                            state_reg;
    logic [bbas_pkg::ADDR_W-1:0]       clr_addr_reg;
    logic [bbas_pkg::TOTAL_BLOCKS-1:0] in_use_reg;
    logic [bbas_pkg::WORD_IDX_W-1:0]   scan_word_reg;
    bbas_pkg::rsp_t                    res_reg;
    logic                              rsp_valid_reg;
    bbas_pkg::rsp_t                    rsp_reg;

    logic [7:0]                        mem [bbas_pkg::DATA_BYTES];
    logic [7:0]                        rd_q_reg;
    logic                              mem_we;
    logic [bbas_pkg::ADDR_W-1:0]       mem_addr;
    logic [7:0]                        mem_wdata;

    logic [bbas_pkg::SCAN_W-1:0]       scan_word;
    logic                              scan_hit;
    logic [bbas_pkg::BIT_IDX_W-1:0]    scan_pos;
    logic                              out_free;
    bbas_pkg::status_t                 use_status;
    bbas_pkg::rsp_t                    start_res;

    assign store_ready = state_reg != S_CLEAR;
    assign cmd_take    = (state_reg == S_IDLE) && cmd_valid;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign out_free    = !rsp_valid_reg || !rsp_stall;

    assign scan_word  = in_use_reg[scan_word_reg * bbas_pkg::SCAN_W +: bbas_pkg::SCAN_W];
    assign scan_hit   = ~scan_word != '0;
    assign scan_pos   = bbas_pkg::first_zero(scan_word);
    assign use_status = in_use_reg[cmd.blk] ? bbas_pkg::ST_OK : bbas_pkg::ST_NOT_IN_USE;

    always_comb
    begin
        start_res = '0;
        unique case (cmd.kind)
            bbas_pkg::CMD_ALLOC:
            begin
                start_res.status = bbas_pkg::ST_OK;
            end
            bbas_pkg::CMD_RELEASE:
            begin
                start_res.result_block = cmd.blk;
            end
            bbas_pkg::CMD_READ, bbas_pkg::CMD_WRITE:
            begin
                start_res.status        = use_status;
                start_res.transfer_last = cmd.last;
            end
            default:
            begin
                start_res.status        = bbas_pkg::ST_PARAM;
                start_res.transfer_last = cmd.last;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = cmd.addr;
        mem_wdata = cmd.wbyte;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = 8'd0;
        end
        else if (cmd_take && cmd.kind == bbas_pkg::CMD_WRITE)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_q_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            scan_word_reg <= '0;
            res_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            for (int i = 0; i < bbas_pkg::TOTAL_BLOCKS; i++)
            begin
                in_use_reg[i] <= i < bbas_pkg::RESERVED_BLOCKS;
            end
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == bbas_pkg::ADDR_W'(bbas_pkg::DATA_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        res_reg <= start_res;
                        unique case (cmd.kind)
                            bbas_pkg::CMD_ALLOC:
                            begin
                                scan_word_reg <= '0;
                                state_reg     <= S_SCAN;
                            end
                            bbas_pkg::CMD_RELEASE:
                            begin
                                in_use_reg[cmd.blk] <= 1'b0;
                                state_reg           <= S_DONE;
                            end
                            bbas_pkg::CMD_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    priority if (scan_hit)
                    begin
                        in_use_reg[{scan_word_reg, scan_pos}] <= 1'b1;
                        res_reg.result_block <= {scan_word_reg, scan_pos};
                        state_reg            <= S_DONE;
                    end
                    else if (scan_word_reg == bbas_pkg::WORD_IDX_W'(bbas_pkg::NUM_WORDS - 1))
                    begin
                        res_reg.status <= bbas_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        scan_word_reg <= scan_word_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    res_reg.read_byte <= rd_q_reg;
                    state_reg         <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/bitmap_block_allocator_store_top.sv
// Block store with an in-use bitmap and a byte-wide data store. Every request
// gives exactly one response, in order. A front stage classifies requests and
// checks block ids and offsets, a two-entry queue decouples it from the back
// end, which owns the bitmap and the data memory and executes one request at
// a time. After reset the data memory is swept to zero, one byte per cycle;
// req_stall stays high until the sweep is done. Allocate scans the bitmap 32
// bits per cycle, over 8 words, in the back end; release, write and parameter
// errors go straight to the response state, and read passes through S_READ
// first because of the registered memory read. The response register lets the back
// end finish the next request while a response is still stalled.
module bitmap_block_allocator_store_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bbas_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bbas_pkg::rsp_t  rsp
);

    logic           store_ready;
    logic           front_valid;
    logic           front_stall;
    bbas_pkg::cmd_t front_cmd;
    logic           queue_valid;
    logic           queue_take;
    bbas_pkg::cmd_t queue_cmd;

    bbas_front u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .store_ready (store_ready),
        .cmd_valid   (front_valid),
        .cmd_stall   (front_stall),
        .cmd         (front_cmd)
    );

    bbas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_take   (queue_take),
        .pop_cmd    (queue_cmd)
    );

    bbas_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (queue_valid),
        .cmd_take    (queue_take),
        .cmd         (queue_cmd),
        .store_ready (store_ready),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule

### tb/allocator_checker.sv
module allocator_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  bbas_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  bbas_pkg::rsp_t rsp,
    output int             mismatches,
    output int             outstanding,
    output int             responses,
    output int             full_hits,
    output int             param_hits,
    output int             free_hits
);

    timeunit 1ns;
    timeprecision 1ps;

    logic           block_taken [bbas_pkg::TOTAL_BLOCKS];
    logic [7:0]     block_bytes [bbas_pkg::DATA_BYTES];
    bbas_pkg::rsp_t pending_outcomes [$];
    bbas_pkg::rsp_t oldest;

    function automatic bit block_id_ok(input logic [7:0] blk);
        return (int'(blk) >= bbas_pkg::RESERVED_BLOCKS)
            && (int'(blk) < bbas_pkg::TOTAL_BLOCKS);
    endfunction

    // applies one request to the shadow bitmap and store, returns the response
    function automatic bbas_pkg::rsp_t run_block_op(input bbas_pkg::req_t r);
        bbas_pkg::rsp_t o;
        bit             found;
        int             idx;
        o     = '0;
        found = 1'b0;
        case (r.operation)
            bbas_pkg::OP_ALLOCATE:
            begin
                for (int i = 0; i < bbas_pkg::TOTAL_BLOCKS && !found; i++)
                begin
                    if (!block_taken[i])
                    begin
                        block_taken[i] = 1'b1;
                        o.result_block = 8'(i);
                        found          = 1'b1;
                    end
                end
                if (!found)
                begin
                    o.status = bbas_pkg::ST_FULL;
                end
            end
            bbas_pkg::OP_RELEASE:
            begin
                if (block_id_ok(r.block_number))
                begin
                    block_taken[r.block_number] = 1'b0;
                    o.result_block              = r.block_number;
                end
                else
                begin
                    o.status = bbas_pkg::ST_PARAM;
                end
            end
            default:
            begin
                o.transfer_last = r.transfer_end;
                if (!block_id_ok(r.block_number)
                    || int'(r.byte_offset) >= bbas_pkg::BLOCK_BYTES)
                begin
                    o.status = bbas_pkg::ST_PARAM;
                end
                else
                begin
                    idx = (int'(r.block_number) - bbas_pkg::RESERVED_BLOCKS)
                        * bbas_pkg::BLOCK_BYTES + int'(r.byte_offset);
                    if (r.operation == bbas_pkg::OP_READ)
                    begin
                        o.read_byte = block_bytes[idx];
                    end
                    else
                    begin
                        block_bytes[idx] = r.write_byte;
                    end
                    o.status = block_taken[r.block_number] ? bbas_pkg::ST_OK
                                                           : bbas_pkg::ST_NOT_IN_USE;
                end
            end
        endcase
        return o;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bbas_pkg::TOTAL_BLOCKS; i++)
            begin
                block_taken[i] = (i < bbas_pkg::RESERVED_BLOCKS);
            end
            for (int i = 0; i < bbas_pkg::DATA_BYTES; i++)
            begin
                block_bytes[i] = 8'd0;
            end
            pending_outcomes.delete();
            mismatches  = 0;
            outstanding = 0;
            responses   = 0;
            full_hits   = 0;
            param_hits  = 0;
            free_hits   = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                responses++;
                if (pending_outcomes.size() == 0)
                begin
                    $error("response with no request pending: block %0d byte %0d status %0d",
                           rsp.result_block, rsp.read_byte, rsp.status);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_outcomes.pop_front();
                    check_field("result_block", oldest.result_block, rsp.result_block);
                    check_field("read_byte", oldest.read_byte, rsp.read_byte);
                    check_field("status", 8'(oldest.status), 8'(rsp.status));
                    check_field("transfer_last", 8'(oldest.transfer_last),
                                8'(rsp.transfer_last));
                    if (oldest.status == bbas_pkg::ST_FULL)
                    begin
                        full_hits++;
                    end
                    if (oldest.status == bbas_pkg::ST_PARAM)
                    begin
                        param_hits++;
                    end
                    if (oldest.status == bbas_pkg::ST_NOT_IN_USE)
                    begin
                        free_hits++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                pending_outcomes.push_back(run_block_op(req));
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_REQS = 1900;
    localparam int IDLE_LIMIT = 60000;
    localparam int LONG_HOLD  = 300;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    bbas_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    bbas_pkg::rsp_t rsp;

    int mismatches;
    int outstanding;
    int responses;
    int full_hits;
    int param_hits;
    int free_hits;
    int sent;
    int idle_cycles;

    bitmap_block_allocator_store_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    allocator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .responses   (responses),
        .full_hits   (full_hits),
        .param_hits  (param_hits),
        .free_hits   (free_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bbas_pkg::req_t make_req(input bbas_pkg::op_t op,
                                                input logic [7:0] blk,
                                                input logic [5:0] off,
                                                input logic [7:0] data,
                                                input logic last_byte);
        bbas_pkg::req_t r;
        r.operation    = op;
        r.block_number = blk;
        r.byte_offset  = off;
        r.write_byte   = data;
        r.transfer_end = last_byte;
        return r;
    endfunction

    // mostly low blocks so that accesses hit both taken and free blocks
    function automatic logic [7:0] pick_block();
        if ($urandom_range(0, 4) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, 63));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input bbas_pkg::req_t r);
        int gap;
        if ((sent % 500) < 100)
        begin
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 12);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        sent++;
        @(negedge clk);
    endtask

    task automatic send_transfer(input bbas_pkg::op_t op, input logic [7:0] blk,
                                 input logic [5:0] start_off, input int len);
        for (int i = 0; i < len; i++)
        begin
            send_req(make_req(op, blk, 6'(start_off + i), 8'($urandom), i == len - 1));
        end
    endtask

    // receiver: random stall per response, quiet stretches, and two long holds
    initial
    begin
        int stall_left;
        int got;
        stall_left = 0;
        got        = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                got++;
                if (got == 600 || got == 1500)
                begin
                    stall_left = LONG_HOLD;
                end
                else if ((got % 500) >= 250 && (got % 500) < 350)
                begin
                    stall_left = 0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 12);
                end
            end
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("** bitmap_block_allocator_store_top: FAILED **");
        $finish;
    end

    initial
    begin
        int pick;
        sent = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send_req(make_req(bbas_pkg::OP_ALLOCATE, 8'd0, 6'd0, 8'd0, 1'b0));
        send_req(make_req(bbas_pkg::OP_ALLOCATE, 8'hFF, 6'h3F, 8'hFF, 1'b1));
        send_req(make_req(bbas_pkg::OP_WRITE, 8'd1, 6'd0, 8'hFF, 1'b1));
        send_req(make_req(bbas_pkg::OP_WRITE, 8'd1, 6'd62, 8'hA5, 1'b0));
        send_req(make_req(bbas_pkg::OP_WRITE, 8'd1, 6'd63, 8'h5A, 1'b1));
        send_req(make_req(bbas_pkg::OP_READ, 8'd1, 6'd62, 8'h00, 1'b0));
        send_req(make_req(bbas_pkg::OP_READ, 8'd1, 6'd63, 8'h00, 1'b1));
        send_req(make_req(bbas_pkg::OP_READ, 8'd1, 6'd0, 8'h00, 1'b1));
        // reserved block id
        send_req(make_req(bbas_pkg::OP_RELEASE, 8'd0, 6'd0, 8'd0, 1'b0));
        send_req(make_req(bbas_pkg::OP_READ, 8'd0, 6'd5, 8'd0, 1'b1));
        send_req(make_req(bbas_pkg::OP_WRITE, 8'd0, 6'd63, 8'hFF, 1'b0));
        // access to free blocks
        send_req(make_req(bbas_pkg::OP_WRITE, 8'd255, 6'd63, 8'hFF, 1'b1));
        send_req(make_req(bbas_pkg::OP_READ, 8'd255, 6'd63, 8'd0, 1'b0));
        send_req(make_req(bbas_pkg::OP_READ, 8'd200, 6'd0, 8'd0, 1'b1));
        // release of a free block, double release, reuse of lowest block
        send_req(make_req(bbas_pkg::OP_RELEASE, 8'd255, 6'd0, 8'd0, 1'b0));
        send_req(make_req(bbas_pkg::OP_RELEASE, 8'd2, 6'd0, 8'd0, 1'b0));
        send_req(make_req(bbas_pkg::OP_RELEASE, 8'd2, 6'd0, 8'd0, 1'b1));
        send_req(make_req(bbas_pkg::OP_READ, 8'd2, 6'd0, 8'd0, 1'b1));
        send_req(make_req(bbas_pkg::OP_ALLOCATE, 8'd0, 6'd0, 8'd0, 1'b0));

        // fill the bitmap until the store is full, then drain it
        for (int i = 0; i < 258; i++)
        begin
            send_req(make_req(bbas_pkg::OP_ALLOCATE, 8'($urandom), 6'($urandom),
                              8'($urandom), 1'($urandom)));
        end
        send_req(make_req(bbas_pkg::OP_READ, 8'd255, 6'd0, 8'd0, 1'b1));
        for (int b = 255; b >= 1; b--)
        begin
            send_req(make_req(bbas_pkg::OP_RELEASE, 8'(b), 6'($urandom), 8'($urandom),
                              1'b0));
        end

        // random traffic, mostly well-formed transfers on low blocks
        while (sent < TOTAL_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    send_req(make_req(bbas_pkg::OP_ALLOCATE, 8'($urandom), 6'($urandom),
                                      8'($urandom), 1'($urandom)));
                end
            end
            else if (pick < 42)
            begin
                send_req(make_req(bbas_pkg::OP_RELEASE, pick_block(), 6'($urandom),
                                  8'($urandom), 1'($urandom)));
            end
            else if (pick < 72)
            begin
                send_transfer(bbas_pkg::OP_WRITE, pick_block(), 6'($urandom),
                              $urandom_range(1, 8));
            end
            else if (pick < 94)
            begin
                send_transfer(bbas_pkg::OP_READ, pick_block(), 6'($urandom),
                              $urandom_range(1, 8));
            end
            else
            begin
                send_req(bbas_pkg::req_t'(25'($urandom)));
            end
        end
        req_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (30) @(posedge clk);
        $display("sent %0d requests and checked %0d responses", sent, responses);
        $display("store full %0d times, bad block id %0d, access to free block %0d",
                 full_hits, param_hits, free_hits);
        if (mismatches == 0)
        begin
            $display("** bitmap_block_allocator_store_top: PASSED **");
        end
        else
        begin
            $display("** bitmap_block_allocator_store_top: FAILED **");
        end
        $finish;
    end

endmodule
